// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only (active-low reset).
`define AST_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== rtl/msmc_pkg.sv =====
package msmc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int SAMPLE_W   = 8;
    localparam int COORD_W    = 11;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int MIN_SIZE   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

    localparam logic [SAMPLE_W-1:0]   ISO_RESET  = 8'd127;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [CODE_W-1:0] CASE_EMPTY    = 4'd0;
    localparam logic [CODE_W-1:0] CASE_FULL     = 4'd15;
    localparam logic [CODE_W-1:0] CASE_SADDLE_A = 4'd5;
    localparam logic [CODE_W-1:0] CASE_SADDLE_B = 4'd10;

    // One closed cell waiting for expansion.
    typedef struct packed {
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [CODE_W-1:0]  code;
    } cell_t;

    // Endpoint offsets in half-cell units.
    typedef struct packed {
        logic [1:0] sx;
        logic [1:0] sy;
        logic [1:0] ex;
        logic [1:0] ey;
    } seg_ofs_t;

    localparam logic [7:0] SEG_FIRST [16] = '{
        8'h00, 8'h16, 8'h69, 8'h19, 8'h49, 8'h69, 8'h46, 8'h14,
        8'h14, 8'h46, 8'h16, 8'h49, 8'h19, 8'h69, 8'h16, 8'h00
    };
    localparam logic [7:0] SEG_SECOND [16] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic seg_ofs_t seg_offsets(input logic [CODE_W-1:0] code,
                                             input logic second);
        seg_ofs_t r;
        r = second ? seg_ofs_t'(SEG_SECOND[code]) : seg_ofs_t'(SEG_FIRST[code]);
        return r;
    endfunction

endpackage

// ===== rtl/msmc_ram.sv =====
module msmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/msmc_front.sv =====
module msmc_front #(
    parameter int MAX_WIDTH  = msmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msmc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [msmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msmc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [msmc_pkg::SAMPLE_W-1:0]    sample,
    input  logic                             q_full,
    output logic                             q_push,
    output msmc_pkg::cell_t                  q_cell
);

    import msmc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WCMP  = ((MAX_WIDTH  > 2047) ? $clog2(MAX_WIDTH + 1)  : CFG_DATA_W) + 1;
    localparam int HCMP  = ((MAX_HEIGHT > 2047) ? $clog2(MAX_HEIGHT + 1) : CFG_DATA_W) + 1;

    logic [SAMPLE_W-1:0]   iso_reg;
    logic [CFG_DATA_W-1:0] gw_reg;
    logic [CFG_DATA_W-1:0] gh_reg;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  left_cur_reg, left_above_reg;
    logic                  run_reg;

    logic            accept, cur, tr, col_wrap, row_wrap;
    logic [WCMP-1:0] w_eff, gw_ext;
    logic [HCMP-1:0] h_eff, gh_ext;
    logic [COL_W-1:0] rd_addr, col_m1;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W:0]   bx_full;
    logic [ROW_W:0]   by_full;
    logic [CODE_W-1:0] code;

    assign s_tready = run_reg && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign cur      = (sample >= iso_reg);

    always_comb begin
        gw_ext = WCMP'(gw_reg);
        gh_ext = HCMP'(gh_reg);
        if (gw_ext < WCMP'(MIN_SIZE)) begin
            w_eff = WCMP'(MIN_SIZE);
        end else if (gw_ext > WCMP'(MAX_WIDTH)) begin
            w_eff = WCMP'(MAX_WIDTH);
        end else begin
            w_eff = gw_ext;
        end
        if (gh_ext < HCMP'(MIN_SIZE)) begin
            h_eff = HCMP'(MIN_SIZE);
        end else if (gh_ext > HCMP'(MAX_HEIGHT)) begin
            h_eff = HCMP'(MAX_HEIGHT);
        end else begin
            h_eff = gh_ext;
        end
        col_wrap = (WCMP'(col_reg) + WCMP'(1)) >= w_eff;
        row_wrap = (HCMP'(row_reg) + HCMP'(1)) >= h_eff;
        col_next = col_wrap ? '0 : col_reg + 1'b1;
        if (!col_wrap) begin
            row_next = row_reg;
        end else if (row_wrap) begin
            row_next = '0;
        end else begin
            row_next = row_reg + 1'b1;
        end
        rd_addr = accept ? col_next : col_reg;
    end

    // Line buffer of inside bits; read data always holds entry col_reg.
    msmc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (cur),
        .rd_addr (rd_addr),
        .rd_data (tr)
    );

    always_comb begin
        col_m1  = col_reg - 1'b1;
        row_m1  = row_reg - 1'b1;
        bx_full = {col_m1, 1'b0};
        by_full = {row_m1, 1'b0};
        code    = {left_above_reg, tr, cur, left_cur_reg};
        q_cell.bx   = COORD_W'(bx_full);
        q_cell.by   = COORD_W'(by_full);
        q_cell.code = code;
        q_push = accept && (col_reg != '0) && (row_reg != '0)
                 && (code != CASE_EMPTY) && (code != CASE_FULL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iso_reg        <= ISO_RESET;
            gw_reg         <= SIZE_RESET;
            gh_reg         <= SIZE_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            left_cur_reg   <= 1'b0;
            left_above_reg <= 1'b0;
            run_reg        <= 1'b0;
        end else begin
            run_reg <= 1'b1;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ISO_LEVEL:   iso_reg <= cfg_wr_data[SAMPLE_W-1:0];
                    REG_GRID_WIDTH:  gw_reg  <= cfg_wr_data;
                    REG_GRID_HEIGHT: gh_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                left_cur_reg   <= cur;
                left_above_reg <= tr;
            end
        end
    end

endmodule

// ===== rtl/msmc_queue.sv =====
module msmc_queue #(
    parameter int DEPTH = msmc_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  msmc_pkg::cell_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output msmc_pkg::cell_t head
);

    import msmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/msmc_back.sv =====
module msmc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  msmc_pkg::cell_t                  q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msmc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    import msmc_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  phase_reg, phase_next;
    logic [COORD_W-1:0]    sx_reg, sy_reg, ex_reg, ey_reg;
    logic                  last_reg;
    logic                  load, saddle, last_seg;
    seg_ofs_t              ofs;

    always_comb begin
        load     = !valid_reg || m_tready;
        saddle   = q_head.code inside {CASE_SADDLE_A, CASE_SADDLE_B};
        last_seg = !saddle || phase_reg;
        ofs      = seg_offsets(q_head.code, phase_reg);
        q_pop    = load && !q_empty && last_seg;
        valid_next = load ? !q_empty : valid_reg;
        phase_next = phase_reg;
        if (load && !q_empty) begin
            phase_next = !last_seg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !q_empty) begin
            sx_reg   <= q_head.bx + COORD_W'(ofs.sx);
            sy_reg   <= q_head.by + COORD_W'(ofs.sy);
            ex_reg   <= q_head.bx + COORD_W'(ofs.ex);
            ey_reg   <= q_head.by + COORD_W'(ofs.ey);
            last_reg <= last_seg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - 4 * COORD_W)'(0), ey_reg, ex_reg, sy_reg, sx_reg};

endmodule

// ===== rtl/marching_squares_midpoint_contour_unit.sv =====
// Throughput: one sample word per cycle while the cell queue is not full; one
// segment word per cycle on m_ while m_tready is high and a cell is queued.
// Saddle cells give two words; a four-entry queue absorbs bursts ahead of the
// output register. Line buffer: one-bit RAM, MAX_WIDTH deep, written and read
// once per sample. Reset (aresetn low, synchronous): counters, left bits,
// queue, output valid and registers to defaults; the line buffer is not cleared.
module marching_squares_midpoint_contour_unit #(
    parameter int MAX_WIDTH  = msmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = msmc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [msmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msmc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [msmc_pkg::S_TDATA_W-1:0]   s_tdata,   // sample[7:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33], zero[47:44]
    output logic [msmc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    import msmc_pkg::*;

    logic  q_full, q_push, q_pop, q_empty;
    cell_t q_cell, q_head;

    msmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cell      (q_cell)
    );

    msmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_cell),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    msmc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/msmc_checker.sv =====
`include "assert_macros.svh"

module msmc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [msmc_pkg::M_TDATA_W-1:0]  m_tdata
);

    import msmc_pkg::*;

    logic [COORD_W-1:0] sx, sy, ex, ey;

    assign sx = m_tdata[COORD_W-1:0];
    assign sy = m_tdata[2*COORD_W-1:COORD_W];
    assign ex = m_tdata[3*COORD_W-1:2*COORD_W];
    assign ey = m_tdata[4*COORD_W-1:3*COORD_W];

    // every endpoint is an edge midpoint: exactly one odd coordinate
    `AST_RUN(a_mid_start, aclk, aresetn, m_tvalid |-> (sx[0] ^ sy[0]), "start not a midpoint")
    `AST_RUN(a_mid_end, aclk, aresetn, m_tvalid |-> (ex[0] ^ ey[0]), "end not a midpoint")
    `AST_RUN(a_nondegen, aclk, aresetn, m_tvalid |-> ((sx != ex) || (sy != ey)), "zero-length segment")
    `AST_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `AST_RUN(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word dropped")

endmodule

bind marching_squares_midpoint_contour_unit msmc_checker u_msmc_checker (.*);

// ===== tb/tb_marching_squares_midpoint_contour_unit.sv =====
`timescale 1ns / 100ps

module tb_marching_squares_midpoint_contour_unit;
    import msmc_pkg::*;

    localparam int LONG_HOLD = 150;

    // 5x5 inside-bit grid, row r in bits [5r+4:5r]; its 16 interior 2x2 windows all differ
    localparam logic [24:0] DIRECTED_BITS =
        {5'b10011, 5'b11001, 5'b00110, 5'b01100, 5'b01100};

    typedef enum logic [1:0] {EDGE_LEFT, EDGE_TOP, EDGE_BOTTOM, EDGE_RIGHT} cell_edge_t;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               last;
    } segment_t;

    class contour_scoreboard;
        logic [SAMPLE_W-1:0]   iso_level  = ISO_RESET;
        logic [CFG_DATA_W-1:0] width_reg  = SIZE_RESET;
        logic [CFG_DATA_W-1:0] height_reg = SIZE_RESET;
        bit                    row_bits [MAX_WIDTH_DEF];
        bit                    left_inside;
        bit                    left_above;
        int unsigned           col_pos;
        int unsigned           row_pos;
        segment_t              segments_due [$];
        int                    errors;

        function void set_regs(input logic [SAMPLE_W-1:0] iso,
                               input logic [CFG_DATA_W-1:0] w,
                               input logic [CFG_DATA_W-1:0] h);
            iso_level  = iso;
            width_reg  = w;
            height_reg = h;
        endfunction

        function int unsigned used_size(input logic [CFG_DATA_W-1:0] v, input int unsigned hi);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > hi) return hi;
            return 32'(v);
        endfunction

        function logic [1:0] mid_x(input cell_edge_t e);
            case (e)
                EDGE_LEFT:  return 2'd0;
                EDGE_RIGHT: return 2'd2;
                default:    return 2'd1;
            endcase
        endfunction

        function logic [1:0] mid_y(input cell_edge_t e);
            case (e)
                EDGE_TOP:    return 2'd0;
                EDGE_BOTTOM: return 2'd2;
                default:     return 2'd1;
            endcase
        endfunction

        function void add_segment(input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                                  input cell_edge_t s, input cell_edge_t e, input logic last);
            segment_t seg;
            seg.sx   = bx + mid_x(s);
            seg.sy   = by + mid_y(s);
            seg.ex   = bx + mid_x(e);
            seg.ey   = by + mid_y(e);
            seg.last = last;
            segments_due.push_back(seg);
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] smp);
            int unsigned        w;
            int unsigned        h;
            int unsigned        c;
            bit                 in_now;
            bit                 above;
            logic [CODE_W-1:0]  code;
            logic [3:0]         crossed;
            logic [COORD_W-1:0] bx;
            logic [COORD_W-1:0] by;
            cell_edge_t         hit [2];
            int                 n;
            w = used_size(width_reg, MAX_WIDTH_DEF);
            h = used_size(height_reg, MAX_HEIGHT_DEF);
            c = col_pos % MAX_WIDTH_DEF;
            in_now = (smp >= iso_level);
            above = row_bits[c];
            if (c >= 1 && row_pos >= 1) begin
                code = {left_above, above, in_now, left_inside};
                bx = COORD_W'(2 * (c - 1));
                by = COORD_W'(2 * (row_pos - 1));
                if (code == CASE_SADDLE_A) begin
                    add_segment(bx, by, EDGE_BOTTOM, EDGE_RIGHT, 1'b0);
                    add_segment(bx, by, EDGE_LEFT, EDGE_TOP, 1'b1);
                end else if (code == CASE_SADDLE_B) begin
                    add_segment(bx, by, EDGE_LEFT, EDGE_BOTTOM, 1'b0);
                    add_segment(bx, by, EDGE_TOP, EDGE_RIGHT, 1'b1);
                end else if (code != CASE_EMPTY && code != CASE_FULL) begin
                    // start on the first crossed edge in left, top, bottom, right order
                    crossed = {above ^ in_now, left_inside ^ in_now,
                               left_above ^ above, left_above ^ left_inside};
                    n = 0;
                    for (int e = 0; e < 4; e++) begin
                        if (crossed[e] && n < 2) begin
                            hit[n] = cell_edge_t'(e);
                            n++;
                        end
                    end
                    add_segment(bx, by, hit[0], hit[1], 1'b1);
                end
            end
            left_above  = above;
            left_inside = in_now;
            row_bits[c] = in_now;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void compare(input string field, input logic [COORD_W-1:0] exp_v,
                              input logic [COORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s expected %0d got %0d", $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_segment(input logic [M_TDATA_W-1:0] data, input logic tlast);
            segment_t want;
            if (segments_due.size() == 0) begin
                $display("%0t: segment word with none expected: data %h last %b",
                         $time, data, tlast);
                errors++;
                return;
            end
            want = segments_due.pop_front();
            compare("start_x", want.sx, data[0 +: COORD_W]);
            compare("start_y", want.sy, data[COORD_W +: COORD_W]);
            compare("end_x", want.ex, data[2*COORD_W +: COORD_W]);
            compare("end_y", want.ey, data[3*COORD_W +: COORD_W]);
            compare("last", COORD_W'(want.last), COORD_W'(tlast));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    contour_scoreboard sb;
    bit                gaps_on;
    bit                stall_req;

    marching_squares_midpoint_contour_unit DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] lvl);
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = lvl;
            1: v = (lvl == 8'd0) ? 8'd0 : lvl - 8'd1;
            2: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: v = SAMPLE_W'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    task automatic configure(input logic [SAMPLE_W-1:0] iso, input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_ISO_LEVEL;
        cfg_wr_data <= CFG_DATA_W'(iso);
        @(negedge aclk);
        cfg_index   <= REG_GRID_WIDTH;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_index   <= REG_GRID_HEIGHT;
        cfg_wr_data <= h;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_regs(iso, w, h);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_sample(smp);
    endtask

    // drop valid, wait out every expected segment, then let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.segments_due.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            gap = gaps_on ? $urandom_range(0, 9) : 0;
            if (stall_req) begin
                gap = LONG_HOLD;
                stall_req = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_segment(m_tdata, m_tlast);
        end
    end

    initial begin
        int                    sent;
        int                    count;
        logic [SAMPLE_W-1:0]   iso;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_ISO_LEVEL;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        gaps_on     = 1'b1;
        stall_req   = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // one 5x5 frame: every case code once, samples at the threshold and the extremes
        configure(8'd128, 11'd5, 11'd5);
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (DIRECTED_BITS[5*r + c])
                    send_sample(((r + c) % 2) ? 8'd255 : 8'd128);
                else
                    send_sample(((r + c) % 2) ? 8'd0 : 8'd127);
            end
        end
        settle();

        // full-width row fills the line buffer, then back-to-back words into a stalled sink
        configure(8'd255, 11'd1024, 11'd2047);
        repeat (MAX_WIDTH_DEF) send_sample(pick_sample(8'd255));
        gaps_on   = 1'b0;
        stall_req = 1'b1;
        repeat (60) send_sample(pick_sample(8'd255));
        settle();
        gaps_on = 1'b1;

        // shrink width below the current column: wraps at once
        configure(8'd0, 11'd7, 11'd0);
        repeat (21) send_sample(pick_sample(8'd0));
        settle();

        configure(8'd127, 11'd0, 11'd1);
        repeat (40) send_sample(pick_sample(8'd127));
        settle();

        sent = 0;
        while (sent < 500) begin
            case ($urandom_range(0, 5))
                0: iso = 8'd0;
                1: iso = 8'd255;
                default: iso = SAMPLE_W'($urandom_range(0, 255));
            endcase
            w = CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                        : $urandom_range(0, 12));
            h = CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                        : $urandom_range(0, 10));
            configure(iso, w, h);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stall_req = ($urandom_range(0, 4) == 0);
            count = $urandom_range(20, 80);
            repeat (count) send_sample(pick_sample(iso));
            sent += count;
            settle();
        end

        if (sb.errors == 0 && sb.segments_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== marching_squares_midpoint_contour_unit.f =====
+incdir+rtl
rtl/msmc_pkg.sv
rtl/msmc_ram.sv
rtl/msmc_front.sv
rtl/msmc_queue.sv
rtl/msmc_back.sv
rtl/marching_squares_midpoint_contour_unit.sv
rtl/msmc_checker.sv
tb/tb_marching_squares_midpoint_contour_unit.sv
